[design/dnsp_pkg.sv]
package dnsp_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IPV6_ENABLE = 4'd1;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_ID_MISMATCH = 3'd2;
  localparam logic [2:0] ST_NOT_RESP    = 3'd3;
  localparam logic [2:0] ST_RCODE       = 3'd4;
  localparam logic [2:0] ST_NO_ANSWERS  = 3'd5;
  localparam logic [2:0] ST_TRUNCATED   = 3'd6;
  localparam logic [2:0] ST_NO_ADDRESS  = 3'd7;

  localparam logic [15:0] FLAG_QR    = 16'h8000;
  localparam logic [15:0] FLAG_RCODE = 16'h000F;
  localparam logic [7:0]  PTR_MASK   = 8'hC0;
  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] TYPE_AAAA  = 16'd28;
  localparam logic [15:0] LEN_A      = 16'd4;
  localparam logic [15:0] LEN_AAAA   = 16'd16;
  localparam logic [15:0] HDR_LEN    = 16'd12;
  localparam logic [15:0] HDR_KEEP   = 16'd8;
  localparam logic [15:0] QFIX_LEN   = 16'd4;
  localparam logic [15:0] AFIX_LEN   = 16'd10;
  localparam logic [15:0] TYPE_BYTES = 16'd2;
  localparam logic [15:0] RLEN_START = 16'd8;
  localparam logic [15:0] ACC_BYTES  = 16'd8;
  localparam logic [15:0] ACC2_END   = 16'd16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic        result_type;
    logic        family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [2:0]  status;
    logic [15:0] address_count;
    logic        last_of_run;
  } dnsp_res_t;

  typedef struct packed {
    logic [15:0] match_id;
    logic        ipv6_enable;
  } dnsp_cfg_t;

  typedef struct packed {
    logic [1:0] cnt;
    dnsp_res_t  first;
    dnsp_res_t  second;
  } dnsp_push_t;

endpackage

[design/dnsp_parser.sv]
module dnsp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  dnsp_pkg::dnsp_cfg_t cfg,
  output dnsp_pkg::dnsp_push_t push
);
  import dnsp_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_NAME   = 3'd1;
  localparam logic [2:0] PH_LABEL  = 3'd2;
  localparam logic [2:0] PH_PTR    = 3'd3;
  localparam logic [2:0] PH_FIXED  = 3'd4;
  localparam logic [2:0] PH_RDATA  = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;
  localparam logic [2:0] PH_ERROR  = 3'd7;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] fc_r, fc_nxt;
  logic [63:0] hs_r, hs_nxt;
  logic [15:0] qleft_r, qleft_nxt;
  logic [15:0] aleft_r, aleft_nxt;
  logic [15:0] rtype_r, rtype_nxt;
  logic [15:0] rlen_r, rlen_nxt;
  logic [63:0] acc0_r, acc0_nxt;
  logic [63:0] acc1_r, acc1_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [15:0] found_r, found_nxt;

  logic [15:0] fc_inc;
  logic [15:0] aleft_dec;
  logic        addr_hit;
  logic        addr_v6;
  dnsp_res_t   addr_res;
  dnsp_res_t   stat_res;

  assign fc_inc    = fc_r + 16'd1;
  assign aleft_dec = aleft_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    hs_nxt    = hs_r;
    qleft_nxt = qleft_r;
    aleft_nxt = aleft_r;
    rtype_nxt = rtype_r;
    rlen_nxt  = rlen_r;
    acc0_nxt  = acc0_r;
    acc1_nxt  = acc1_r;
    err_nxt   = err_r;
    found_nxt = found_r;
    addr_hit  = 1'b0;
    addr_v6   = 1'b0;
    unique case (phase_r)
      PH_HEADER: begin
        if (fc_r < HDR_KEEP) hs_nxt = {hs_r[55:0], data_byte};
        fc_nxt = fc_inc;
        if (fc_inc == HDR_LEN) begin
          fc_nxt = '0;
          if (hs_r[63:48] != cfg.match_id) begin
            err_nxt = ST_ID_MISMATCH;
            phase_nxt = PH_ERROR;
          end else if ((hs_r[47:32] & FLAG_QR) == 16'd0) begin
            err_nxt = ST_NOT_RESP;
            phase_nxt = PH_ERROR;
          end else if ((hs_r[47:32] & FLAG_RCODE) != 16'd0) begin
            err_nxt = ST_RCODE;
            phase_nxt = PH_ERROR;
          end else if (hs_r[15:0] == 16'd0) begin
            err_nxt = ST_NO_ANSWERS;
            phase_nxt = PH_ERROR;
          end else begin
            qleft_nxt = hs_r[31:16];
            aleft_nxt = hs_r[15:0];
            phase_nxt = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (data_byte == 8'd0) begin
          fc_nxt = '0;
          phase_nxt = PH_FIXED;
        end else if ((data_byte & PTR_MASK) == PTR_MASK) begin
          phase_nxt = PH_PTR;
        end else begin
          fc_nxt = {8'd0, data_byte};
          phase_nxt = PH_LABEL;
        end
      end
      PH_LABEL: begin
        fc_nxt = fc_r - 16'd1;
        if (fc_r == 16'd1) phase_nxt = PH_NAME;
      end
      PH_PTR: begin
        fc_nxt = '0;
        phase_nxt = PH_FIXED;
      end
      PH_FIXED: begin
        if (qleft_r != 16'd0) begin
          fc_nxt = fc_inc;
          if (fc_inc == QFIX_LEN) begin
            qleft_nxt = qleft_r - 16'd1;
            fc_nxt = '0;
            phase_nxt = PH_NAME;
          end
        end else begin
          if (fc_r < TYPE_BYTES) rtype_nxt = {rtype_r[7:0], data_byte};
          else if (fc_r >= RLEN_START) rlen_nxt = {rlen_r[7:0], data_byte};
          fc_nxt = fc_inc;
          if (fc_inc == AFIX_LEN) begin
            fc_nxt = '0;
            acc0_nxt = '0;
            acc1_nxt = '0;
            if (rlen_nxt == 16'd0) begin
              aleft_nxt = aleft_dec;
              phase_nxt = (aleft_dec == 16'd0) ? PH_DONE : PH_NAME;
            end else begin
              phase_nxt = PH_RDATA;
            end
          end
        end
      end
      PH_RDATA: begin
        if (fc_r < ACC_BYTES) acc0_nxt = {acc0_r[55:0], data_byte};
        else if (fc_r < ACC2_END) acc1_nxt = {acc1_r[55:0], data_byte};
        fc_nxt = fc_inc;
        if (fc_inc == rlen_r) begin
          if (rtype_r == TYPE_A && rlen_r == LEN_A) begin
            addr_hit = 1'b1;
          end else if (cfg.ipv6_enable && rtype_r == TYPE_AAAA && rlen_r == LEN_AAAA) begin
            addr_hit = 1'b1;
            addr_v6 = 1'b1;
          end
          if (addr_hit) found_nxt = found_r + 16'd1;
          rtype_nxt = '0;
          rlen_nxt = '0;
          aleft_nxt = aleft_dec;
          fc_nxt = '0;
          phase_nxt = (aleft_dec == 16'd0) ? PH_DONE : PH_NAME;
        end
      end
      PH_DONE, PH_ERROR: begin
      end
      default: begin
      end
    endcase

    addr_res = '0;
    addr_res.family = addr_v6;
    addr_res.addr_high = addr_v6 ? acc0_nxt : 64'd0;
    addr_res.addr_low = addr_v6 ? acc1_nxt : {32'd0, acc0_nxt[31:0]};

    stat_res = '0;
    stat_res.result_type = 1'b1;
    stat_res.last_of_run = 1'b1;
    if (phase_nxt == PH_ERROR) begin
      stat_res.status = err_nxt;
    end else if (phase_nxt == PH_HEADER) begin
      stat_res.status = ST_SHORT;
    end else if (phase_nxt == PH_DONE) begin
      if (found_nxt != 16'd0) begin
        stat_res.status = ST_OK;
        stat_res.address_count = found_nxt;
      end else begin
        stat_res.status = ST_NO_ADDRESS;
      end
    end else begin
      stat_res.status = ST_TRUNCATED;
    end

    if (last_byte) begin
      phase_nxt = PH_HEADER;
      fc_nxt    = '0;
      hs_nxt    = '0;
      qleft_nxt = '0;
      aleft_nxt = '0;
      rtype_nxt = '0;
      rlen_nxt  = '0;
      acc0_nxt  = '0;
      acc1_nxt  = '0;
      err_nxt   = '0;
      found_nxt = '0;
    end

    push.first  = addr_hit ? addr_res : stat_res;
    push.second = stat_res;
    if (!accept) push.cnt = 2'd0;
    else push.cnt = {1'b0, addr_hit} + {1'b0, last_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      fc_r    <= '0;
      hs_r    <= '0;
      qleft_r <= '0;
      aleft_r <= '0;
      rtype_r <= '0;
      rlen_r  <= '0;
      acc0_r  <= '0;
      acc1_r  <= '0;
      err_r   <= '0;
      found_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      hs_r    <= hs_nxt;
      qleft_r <= qleft_nxt;
      aleft_r <= aleft_nxt;
      rtype_r <= rtype_nxt;
      rlen_r  <= rlen_nxt;
      acc0_r  <= acc0_nxt;
      acc1_r  <= acc1_nxt;
      err_r   <= err_nxt;
      found_r <= found_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> phase_r == PH_HEADER && found_r == 16'd0)
    else $error("parser did not restart after the last byte");
  a_rdata_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RDATA |-> rlen_r != 16'd0 && fc_r < rlen_r)
    else $error("rdata phase with bad length or counter");
  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |-> err_r >= ST_ID_MISMATCH && err_r <= ST_NO_ANSWERS)
    else $error("error phase without a header error code");
`endif

endmodule

[design/dnsp_out_fifo.sv]
module dnsp_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dnsp_pkg::dnsp_push_t push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dnsp_pkg::dnsp_res_t  out_res
);
  import dnsp_pkg::*;

  dnsp_res_t mem [FIFO_DEPTH];

  logic [FIFO_AW-1:0] head_r, head_nxt;
  logic [FIFO_AW-1:0] tail_r, tail_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic [FIFO_AW-1:0] tail_p1;
  logic               pop;

  assign room      = count_r <= FIFO_CW'(FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_res   = mem[head_r];
  assign pop       = out_valid && out_ready;
  assign tail_p1   = tail_r + FIFO_AW'(1);

  assign head_nxt  = head_r + FIFO_AW'(pop);
  assign tail_nxt  = tail_r + FIFO_AW'(push.cnt);
  assign count_nxt = count_r + FIFO_CW'(push.cnt) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[tail_r] <= push.first;
    if (push.cnt == 2'd2) mem[tail_p1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> count_r + FIFO_CW'(push.cnt) <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != FIFO_CW'(FIFO_DEPTH) |-> FIFO_AW'(tail_r - head_r) == count_r[FIFO_AW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

[design/dns_response_address_parser_top.sv]
// Byte-serial DNS response parser: takes one message byte per cycle and emits an
// address item for every A record (and AAAA record when ipv6_enable is set), then
// a final status item on the last byte. Header state, name skipping and record
// capture all update in the same cycle a byte is accepted, so a byte enters every
// cycle while in_ready is high; results drain through a four-entry queue at one
// item per cycle while out_ready is high, and in_ready drops only while fewer
// than two queue slots are free (a byte that completes an address and ends the
// message pushes two items). A status other than ok means the address items of
// that message must be discarded. Configuration writes must be issued while idle.
module dns_response_address_parser_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_result_type,
  output logic                           out_family,
  output logic [63:0]                    out_addr_high,
  output logic [63:0]                    out_addr_low,
  output logic [2:0]                     out_status,
  output logic [15:0]                    out_address_count,
  output logic                           out_last_of_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dnsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dnsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dnsp_pkg::*;

  dnsp_cfg_t  cfg_r;
  dnsp_push_t push;
  dnsp_res_t  res;
  logic       room;
  logic       in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_id    <= '0;
      cfg_r.ipv6_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MATCH_ID:    cfg_r.match_id <= cfg_data;
        REG_IPV6_ENABLE: cfg_r.ipv6_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  dnsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cfg       (cfg_r),
    .push      (push)
  );

  dnsp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_result_type   = res.result_type;
  assign out_family        = res.family;
  assign out_addr_high     = res.addr_high;
  assign out_addr_low      = res.addr_low;
  assign out_status        = res.status;
  assign out_address_count = res.address_count;
  assign out_last_of_run   = res.last_of_run;

endmodule
